// File: rtl/core/ssirl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssirl_pkg: shared definitions for the small set block
// Operation and status codes, field widths and the result record that
// travels from the sequencer to the output register.
// ----------------------------------------------------------------------------
package ssirl_pkg;

   localparam int DEFAULT_CAPACITY = 64;

   localparam int OP_W      = 2;
   localparam int VALUE_W   = 32;
   localparam int STATUS_W  = 2;
   localparam int ENTRY_W   = 7;
   localparam int RSP_DATA_W = 16;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_PRESENT   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [ENTRY_W-1:0]  entry_count;
      logic                was_present;
      logic [STATUS_W-1:0] status;
   } res_type;

endpackage
`default_nettype wire

// File: rtl/core/ssirl_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssirl_mem: entry store
// Single-port-write, single-port-read synchronous RAM with registered read
// data.
// ----------------------------------------------------------------------------
module ssirl_mem #(
   parameter int DEPTH = ssirl_pkg::DEFAULT_CAPACITY,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [ADDR_W-1:0]             wr_addr,
   input  wire logic [ssirl_pkg::VALUE_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0]             rd_addr,
   output logic      [ssirl_pkg::VALUE_W-1:0] rd_data
);

   logic [ssirl_pkg::VALUE_W-1:0] mem [DEPTH];
   logic [ssirl_pkg::VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: rtl/core/ssirl_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssirl_ctrl: set sequencer
// Scans the stored entries one per cycle, appends on insert, and on remove
// moves every later entry down one place with a read-ahead copy loop.
// ----------------------------------------------------------------------------
module ssirl_ctrl #(
   parameter int CAPACITY = ssirl_pkg::DEFAULT_CAPACITY,
   localparam int ADDR_W = $clog2(CAPACITY),
   localparam int CNT_W  = $clog2(CAPACITY + 1)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [ssirl_pkg::OP_W-1:0]    req_op,
   input  wire logic [ssirl_pkg::VALUE_W-1:0] req_value,
   output logic                               res_valid,
   input  wire logic                          res_take,
   output ssirl_pkg::res_type                 res,
   output logic                               wr_en,
   output logic      [ADDR_W-1:0]             wr_addr,
   output logic      [ssirl_pkg::VALUE_W-1:0] wr_data,
   output logic      [ADDR_W-1:0]             rd_addr,
   input  wire logic [ssirl_pkg::VALUE_W-1:0] rd_data
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_SHIFT = 4'b0100,
      ST_RESP  = 4'b1000
   } state_type;

   state_type                       state_ff, state_in;
   logic [CNT_W-1:0]                count_ff, count_in;
   logic [ADDR_W-1:0]               idx_ff, idx_in;
   logic [ssirl_pkg::OP_W-1:0]      op_ff, op_in;
   logic [ssirl_pkg::VALUE_W-1:0]   value_ff, value_in;
   logic [ssirl_pkg::STATUS_W-1:0]  status_ff, status_in;
   logic                            present_ff, present_in;

   logic                            fin;
   logic                            fin_present;
   logic [ssirl_pkg::OP_W-1:0]      cur_op;
   logic [ssirl_pkg::VALUE_W-1:0]   cur_value;
   logic [CNT_W-1:0]                idx_ext;
   logic                            idx_last;
   logic [CNT_W+ssirl_pkg::ENTRY_W-1:0] count_wide;

   assign idx_ext  = CNT_W'(idx_ff);
   assign idx_last = (idx_ext == count_ff - CNT_W'(1));

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      op_in       = op_ff;
      value_in    = value_ff;
      status_in   = status_ff;
      present_in  = present_ff;
      req_ready   = 1'b0;
      rd_addr     = idx_ff + ADDR_W'(1);
      wr_en       = 1'b0;
      wr_addr     = idx_ff - ADDR_W'(1);
      wr_data     = rd_data;
      fin         = 1'b0;
      fin_present = 1'b0;
      cur_op      = op_ff;
      cur_value   = value_ff;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            rd_addr   = '0;
            if (req_valid) begin
               op_in     = req_op;
               value_in  = req_value;
               cur_op    = req_op;
               cur_value = req_value;
               idx_in    = '0;
               if (count_ff == '0) begin
                  fin = 1'b1;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // Read data belongs to idx_ff; the next address is already issued.
            if (rd_data == value_ff) begin
               fin         = 1'b1;
               fin_present = 1'b1;
            end else if (idx_last) begin
               fin = 1'b1;
            end else begin
               idx_in = idx_ff + ADDR_W'(1);
            end
         end
         ST_SHIFT: begin
            // Entry idx_ff arrives now and moves down to idx_ff - 1.
            wr_en = 1'b1;
            if (idx_last) begin
               count_in = count_ff - CNT_W'(1);
               state_in = ST_RESP;
            end else begin
               idx_in = idx_ff + ADDR_W'(1);
            end
         end
         ST_RESP: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (fin) begin
         present_in = fin_present;
         state_in   = ST_RESP;
         case (cur_op)
            ssirl_pkg::OP_INSERT: begin
               if (fin_present) begin
                  status_in = ssirl_pkg::STATUS_PRESENT;
               end else if (count_ff == CNT_W'(CAPACITY)) begin
                  status_in = ssirl_pkg::STATUS_FULL;
               end else begin
                  status_in = ssirl_pkg::STATUS_DONE;
                  wr_en     = 1'b1;
                  wr_addr   = count_ff[ADDR_W-1:0];
                  wr_data   = cur_value;
                  count_in  = count_ff + CNT_W'(1);
               end
            end
            ssirl_pkg::OP_REMOVE: begin
               if (fin_present) begin
                  status_in = ssirl_pkg::STATUS_DONE;
                  if (idx_last) begin
                     count_in = count_ff - CNT_W'(1);
                  end else begin
                     // The read of the following entry went out this cycle.
                     state_in = ST_SHIFT;
                     idx_in   = idx_ff + ADDR_W'(1);
                  end
               end else begin
                  status_in = ssirl_pkg::STATUS_NOT_FOUND;
               end
            end
            default: begin
               status_in = fin_present ? ssirl_pkg::STATUS_DONE
                                       : ssirl_pkg::STATUS_NOT_FOUND;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      idx_ff     <= idx_in;
      op_ff      <= op_in;
      value_ff   <= value_in;
      status_ff  <= status_in;
      present_ff <= present_in;
   end

   assign count_wide      = {{ssirl_pkg::ENTRY_W{1'b0}}, count_ff};
   assign res_valid       = (state_ff == ST_RESP);
   assign res.status      = status_ff;
   assign res.was_present = present_ff;
   assign res.entry_count = count_wide[ssirl_pkg::ENTRY_W-1:0];

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("stored count exceeds capacity");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (count_ff == $past(count_ff)
                         || count_ff == $past(count_ff) + CNT_W'(1)
                         || count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("stored count moved by more than one");

   a_shift_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SHIFT |-> (idx_ext < count_ff && idx_ff != '0))
      else $error("shift index outside the stored entries");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP && status_ff == ssirl_pkg::STATUS_FULL)
      |-> count_ff == CNT_W'(CAPACITY))
      else $error("full status reported while store has room");

endmodule
`default_nettype wire

// File: rtl/core/small_set_insert_remove_lookup.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// small_set_insert_remove_lookup: set of distinct 32-bit values
// Insert, remove and membership query on a set held in insertion order.
//
// Request channel (req_): one transaction carries an operation in tuser and
// a value in tdata. Response channel (rsp_): one transaction per request
// with status, was-present flag and the entry count after the operation.
// Requests are handled one at a time. An insert or query scans the stored
// entries in order until it finds the value or has read the last one; an
// insert that misses then appends the value. A remove that hits entry s
// scans s + 1 entries and then moves the N - s - 1 later entries of the N
// stored down one place; a remove that misses scans all N. The next request
// is accepted once the response has moved into the output register. The
// scan and the move walk the entry RAM one entry per cycle through its
// single read port. An output register holds the response, so one more
// request is accepted while the receiver stalls; its response then waits
// in the sequencer until the register frees. Reset empties the set at
// once; the entry RAM itself is not cleared. Inserting a value that is not
// already present into a full set drops it and reports full.
// ----------------------------------------------------------------------------
module small_set_insert_remove_lookup #(
   parameter int CAPACITY = ssirl_pkg::DEFAULT_CAPACITY
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] value
   input  wire logic [1:0]  req_tuser,   // [1:0] op
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata    // [1:0] status, [2] was_present,
                                         // [9:3] entry_count, [15:10] zero
);

   localparam int ADDR_W = $clog2(CAPACITY);

   logic                            res_valid;
   logic                            res_take;
   ssirl_pkg::res_type              res;
   logic                            wr_en;
   logic [ADDR_W-1:0]               wr_addr;
   logic [ssirl_pkg::VALUE_W-1:0]   wr_data;
   logic [ADDR_W-1:0]               rd_addr;
   logic [ssirl_pkg::VALUE_W-1:0]   rd_data;

   logic                            rsp_valid_ff, rsp_valid_in;
   ssirl_pkg::res_type              rsp_data_ff, rsp_data_in;

   ssirl_mem #(
      .DEPTH (CAPACITY)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ssirl_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_op    (req_tuser),
      .req_value (req_tdata),
      .res_valid (res_valid),
      .res_take  (res_take),
      .res       (res),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   // The output register takes a new response when empty or being drained.
   assign res_take = res_valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(ssirl_pkg::RSP_DATA_W - $bits(ssirl_pkg::res_type)){1'b0}},
                        rsp_data_ff};

endmodule
`default_nettype wire
